### src/ihcp_pkg.sv
// Shared types and constants for the IPv6 header chain parser.
`default_nettype none
package ihcp_pkg;
	localparam int LEN_WIDTH = 16;
	localparam logic [LEN_WIDTH-1:0] BYTE_MAX = '1;
	localparam logic [LEN_WIDTH-1:0] FIXED_LEN = LEN_WIDTH'(40);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TRUNC = 2'd1;
	localparam logic [1:0] ST_BADVER = 2'd2;

	localparam logic [7:0] NH_HOP = 8'd0;
	localparam logic [7:0] NH_ROUTE = 8'd43;
	localparam logic [7:0] NH_FRAG = 8'd44;
	localparam logic [7:0] NH_AUTH = 8'd51;
	localparam logic [7:0] NH_DEST = 8'd60;

	typedef enum logic [2:0] {
		PH_FIXED = 3'd0,
		PH_START = 3'd1,
		PH_LEN = 3'd2,
		PH_BODY = 3'd3,
		PH_DONE = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_EIGHT = 2'd0,
		KIND_FRAG = 2'd1,
		KIND_AUTH = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] upper_protocol;
		logic [15:0] header_bytes;
		logic is_fragment;
		logic [12:0] frag_offset;
		logic frag_more;
	} out_item_t;

	// Summary of one packet handed from the parser to the result stage.
	typedef struct packed {
		logic [LEN_WIDTH-1:0] len;
		logic version_bad;
		logic [LEN_WIDTH-1:0] payload_length;
		logic mid_header;
		logic [7:0] current_next;
		logic [LEN_WIDTH-1:0] chain_end;
		logic frag_seen;
		logic [15:0] frag_word;
	} summary_t;
endpackage
`default_nettype wire

### src/ihcp_front.sv
// Byte parser: walks the fixed header and extension chain, emits a packet summary.
`default_nettype none
module ihcp_front (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_ready,
	input ihcp_pkg::in_item_t in_item,
	output logic sum_valid,
	input wire sum_ready,
	output ihcp_pkg::summary_t sum_item
);
	import ihcp_pkg::*;

	logic [LEN_WIDTH-1:0] byte_count_q, chain_end_q, payload_length_q;
	phase_t phase_q;
	logic [11:0] header_left_q;
	logic [7:0] current_next_q;
	logic version_bad_q, frag_seen_q;
	kind_t kind_q;
	logic [15:0] frag_word_q;

	logic [LEN_WIDTH-1:0] bc_n, ce_n, pl_n;
	phase_t ph_n;
	logic [11:0] hl_n;
	logic [7:0] cn_n;
	logic vb_n, fs_n;
	kind_t kd_n;
	logic [15:0] fw_n;
	logic [11:0] total;
	logic [LEN_WIDTH:0] ce_sum;
	logic [7:0] b;
	logic acc;

	assign in_ready = !sum_valid || sum_ready;
	assign acc = in_valid && in_ready;
	assign b = in_item.data_byte;

	always_comb begin
		bc_n = byte_count_q;
		ce_n = chain_end_q;
		pl_n = payload_length_q;
		ph_n = phase_q;
		hl_n = header_left_q;
		cn_n = current_next_q;
		vb_n = version_bad_q;
		fs_n = frag_seen_q;
		kd_n = kind_q;
		fw_n = frag_word_q;
		total = 12'd8;
		ce_sum = '0;
		if (byte_count_q != BYTE_MAX) begin
			bc_n = byte_count_q + 1'b1;
			unique case (phase_q)
				PH_FIXED: begin
					if (byte_count_q == LEN_WIDTH'(0)) vb_n = (b[7:4] != 4'd6);
					if (byte_count_q == LEN_WIDTH'(4)) pl_n = LEN_WIDTH'({b, payload_length_q[7:0]});
					if (byte_count_q == LEN_WIDTH'(5)) pl_n = {payload_length_q[LEN_WIDTH-1:8], b};
					if (byte_count_q == LEN_WIDTH'(6)) cn_n = b;
					if (byte_count_q == FIXED_LEN - 1'b1) ph_n = PH_START;
				end
				PH_START: begin
					ph_n = PH_LEN;
					cn_n = b;
					priority if (current_next_q == NH_HOP || current_next_q == NH_ROUTE
						|| current_next_q == NH_DEST) kd_n = KIND_EIGHT;
					else if (current_next_q == NH_FRAG) begin
						kd_n = KIND_FRAG;
						fs_n = 1'b1;
					end else if (current_next_q == NH_AUTH) kd_n = KIND_AUTH;
					else begin
						ph_n = PH_DONE;
						cn_n = current_next_q;
					end
				end
				PH_LEN: begin
					unique case (kind_q)
						KIND_EIGHT: total = {1'b0, b, 3'b0} + 12'd8;
						KIND_AUTH: total = {2'b0, b, 2'b0} + 12'd8;
						default: total = 12'd8;
					endcase
					ce_sum = {1'b0, chain_end_q} + (LEN_WIDTH+1)'(total);
					ce_n = ce_sum[LEN_WIDTH] ? BYTE_MAX : ce_sum[LEN_WIDTH-1:0];
					hl_n = total - 12'd2;
					ph_n = (hl_n == 12'd0) ? PH_START : PH_BODY;
				end
				PH_BODY: begin
					if (kind_q == KIND_FRAG && header_left_q == 12'd6) fw_n[15:8] = b;
					if (kind_q == KIND_FRAG && header_left_q == 12'd5) fw_n[7:0] = b;
					hl_n = header_left_q - 1'b1;
					if (hl_n == 12'd0) ph_n = PH_START;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			chain_end_q <= FIXED_LEN;
			payload_length_q <= '0;
			phase_q <= PH_FIXED;
			header_left_q <= '0;
			current_next_q <= '0;
			version_bad_q <= 1'b0;
			frag_seen_q <= 1'b0;
			kind_q <= KIND_EIGHT;
			frag_word_q <= '0;
			sum_valid <= 1'b0;
		end else begin
			if (acc && in_item.last_byte) sum_valid <= 1'b1;
			else if (sum_ready) sum_valid <= 1'b0;
			if (acc) begin
				if (in_item.last_byte) begin
					byte_count_q <= '0;
					chain_end_q <= FIXED_LEN;
					payload_length_q <= '0;
					phase_q <= PH_FIXED;
					header_left_q <= '0;
					current_next_q <= '0;
					version_bad_q <= 1'b0;
					frag_seen_q <= 1'b0;
					kind_q <= KIND_EIGHT;
					frag_word_q <= '0;
				end else begin
					byte_count_q <= bc_n;
					chain_end_q <= ce_n;
					payload_length_q <= pl_n;
					phase_q <= ph_n;
					header_left_q <= hl_n;
					current_next_q <= cn_n;
					version_bad_q <= vb_n;
					frag_seen_q <= fs_n;
					kind_q <= kd_n;
					frag_word_q <= fw_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_item.last_byte) begin
			sum_item.len <= bc_n;
			sum_item.version_bad <= vb_n;
			sum_item.payload_length <= pl_n;
			sum_item.mid_header <= (ph_n == PH_LEN || ph_n == PH_BODY);
			sum_item.current_next <= cn_n;
			sum_item.chain_end <= ce_n;
			sum_item.frag_seen <= fs_n;
			sum_item.frag_word <= fw_n;
		end
	end

`ifndef SYNTHESIS
	a_cnt_rst: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_item.last_byte |=> byte_count_q == '0 && phase_q == PH_FIXED)
		else $error("counter not cleared after packet");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && !sum_ready |=> sum_valid && $stable(sum_item))
		else $error("summary lost under stall");
	a_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> header_left_q != 12'd0)
		else $error("body phase with nothing left");
`endif
endmodule
`default_nettype wire

### src/ihcp_back.sv
// Result stage: turns a packet summary into the result item.
`default_nettype none
module ihcp_back (
	input wire clk,
	input wire arst_n,
	input wire sum_valid,
	output logic sum_ready,
	input ihcp_pkg::summary_t sum_item,
	output logic out_valid,
	input wire out_ready,
	output ihcp_pkg::out_item_t out_item
);
	import ihcp_pkg::*;

	out_item_t res;
	logic [LEN_WIDTH:0] need;

	assign sum_ready = !out_valid || out_ready;

	always_comb begin
		need = {1'b0, FIXED_LEN} + {1'b0, sum_item.payload_length};
		res = '0;
		priority if (sum_item.len < FIXED_LEN) res.status = ST_TRUNC;
		else if (sum_item.version_bad) res.status = ST_BADVER;
		else if (need > {1'b0, sum_item.len}) res.status = ST_TRUNC;
		else if (sum_item.mid_header) res.status = ST_TRUNC;
		else begin
			res.status = ST_OK;
			res.upper_protocol = sum_item.current_next;
			res.header_bytes = sum_item.chain_end[15:0];
			res.is_fragment = sum_item.frag_seen && ((sum_item.frag_word & 16'hFFF9) != 16'd0);
			res.frag_offset = sum_item.frag_word[15:3];
			res.frag_more = sum_item.frag_word[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (sum_ready) out_valid <= sum_valid;
	end

	always_ff @(posedge clk) begin
		if (sum_valid && sum_ready) out_item <= res;
	end

`ifndef SYNTHESIS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |-> out_item.header_bytes == 16'd0)
		else $error("failed packet carries header bytes");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_ready |=> out_valid)
		else $error("summary dropped");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status != 2'd3)
		else $error("bad status code");
`endif
endmodule
`default_nettype wire

### src/ipv6_header_chain_parser.sv
// Top level of the IPv6 header chain parser.
// channel | handshake               | payload
// in      | in_valid / in_ready     | in_item  (data_byte, last_byte)
// out     | out_valid / out_ready   | out_item (status .. frag_more)
// One byte per cycle is accepted while the summary register is free.
// The result is registered first in the parser's summary register, then in the result stage.
// Reset clears all parser state; payload registers are not reset.
// An output stall backs up through the result stage into the parser.
`default_nettype none
module ipv6_header_chain_parser (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_ready,
	input ihcp_pkg::in_item_t in_item,
	output logic out_valid,
	input wire out_ready,
	output ihcp_pkg::out_item_t out_item
);
	import ihcp_pkg::*;

	logic sum_valid, sum_ready;
	summary_t sum_item;

	ihcp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.sum_valid(sum_valid), .sum_ready(sum_ready), .sum_item(sum_item)
	);

	ihcp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.sum_valid(sum_valid), .sum_ready(sum_ready), .sum_item(sum_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule
`default_nettype wire

### bench/tb_ipv6_header_chain_parser.sv
// Testbench for the IPv6 header chain parser: packet stimulus, predictor and scoreboard.
`default_nettype none
module tb_ipv6_header_chain_parser;
	import ihcp_pkg::*;

	class parse_scoreboard;
		out_item_t pending[$];
		int errors;
		logic [15:0] cnt;
		phase_t phase;
		logic [11:0] left;
		logic [7:0] nxt;
		logic [15:0] cend;
		logic [15:0] plen;
		logic vbad;
		kind_t kind;
		logic [15:0] fword;
		logic fseen;

		function void clear();
			cnt = 0; phase = PH_FIXED; left = 0; nxt = 0; cend = 16'd40;
			plen = 0; vbad = 0; kind = KIND_EIGHT; fword = 0; fseen = 0;
		endfunction

		function void take(logic [7:0] b);
			int total;
			case (phase)
				PH_FIXED: begin
					if (cnt == 0) vbad = (b[7:4] != 4'd6);
					else if (cnt == 4) plen[15:8] = b;
					else if (cnt == 5) plen[7:0] = b;
					else if (cnt == 6) nxt = b;
					if (cnt == 39) phase = PH_START;
				end
				PH_START: begin
					if (nxt == NH_HOP || nxt == NH_ROUTE || nxt == NH_DEST) begin
						kind = KIND_EIGHT;
					end else if (nxt == NH_FRAG) begin
						kind = KIND_FRAG; fseen = 1;
					end else if (nxt == NH_AUTH) begin
						kind = KIND_AUTH;
					end else begin
						phase = PH_DONE;
						return;
					end
					nxt = b;
					phase = PH_LEN;
				end
				PH_LEN: begin
					if (kind == KIND_EIGHT) total = (b + 1) * 8;
					else if (kind == KIND_AUTH) total = (b + 2) * 4;
					else total = 8;
					total = total + cend;
					cend = (total > 65535) ? 16'hFFFF : total[15:0];
					left = 12'((kind == KIND_EIGHT) ? (b + 1) * 8 - 2 :
						(kind == KIND_AUTH) ? (b + 2) * 4 - 2 : 6);
					phase = (left == 0) ? PH_START : PH_BODY;
				end
				PH_BODY: begin
					if (kind == KIND_FRAG) begin
						if (left == 6) fword[15:8] = b;
						else if (left == 5) fword[7:0] = b;
					end
					left = left - 1;
					if (left == 0) phase = PH_START;
				end
				default: ;
			endcase
		endfunction

		function void note_byte(in_item_t it);
			out_item_t r;
			if (cnt != 16'hFFFF) begin
				take(it.data_byte);
				cnt++;
			end
			if (!it.last_byte) return;
			r = '0;
			if (cnt < 40) r.status = ST_TRUNC;
			else if (vbad) r.status = ST_BADVER;
			else if (17'd40 + plen > {1'b0, cnt}) r.status = ST_TRUNC;
			else if (phase == PH_LEN || phase == PH_BODY) r.status = ST_TRUNC;
			else r.status = ST_OK;
			if (r.status == ST_OK) begin
				r.upper_protocol = nxt;
				r.header_bytes = cend;
				r.is_fragment = fseen && ((fword & 16'hFFF9) != 0);
				r.frag_offset = fword[15:3];
				r.frag_more = fword[0];
			end
			pending.push_back(r);
			clear();
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, got.status); errors++;
			end
			if (got.upper_protocol !== e.upper_protocol) begin
				$error("upper_protocol exp %0d got %0d", e.upper_protocol, got.upper_protocol);
				errors++;
			end
			if (got.header_bytes !== e.header_bytes) begin
				$error("header_bytes exp %0d got %0d", e.header_bytes, got.header_bytes);
				errors++;
			end
			if (got.is_fragment !== e.is_fragment) begin
				$error("is_fragment exp %0d got %0d", e.is_fragment, got.is_fragment); errors++;
			end
			if (got.frag_offset !== e.frag_offset) begin
				$error("frag_offset exp %0d got %0d", e.frag_offset, got.frag_offset); errors++;
			end
			if (got.frag_more !== e.frag_more) begin
				$error("frag_more exp %0d got %0d", e.frag_more, got.frag_more);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 0;
	out_item_t out_item;
	parse_scoreboard sb;
	int burst_left = 0;
	int stall_mode = 0;
	int byte_total = 0;
	logic [7:0] pkt[$];

	ipv6_header_chain_parser u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_ipv6_header_chain_parser NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(out_item);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
	end

	task automatic send_byte(logic [7:0] b, logic l);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item <= '{data_byte: b, last_byte: l};
		do @(posedge clk); while (!in_ready);
		sb.note_byte('{data_byte: b, last_byte: l});
		byte_total++;
	endtask

	task automatic send_packet();
		foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	function automatic logic [7:0] pick_nh();
		case ($urandom_range(0, 7))
			0: return NH_HOP;
			1: return NH_ROUTE;
			2: return NH_DEST;
			3: return NH_FRAG;
			4: return NH_AUTH;
			5: return 8'd59;
			6: return 8'd6;
			default: return 8'($urandom);
		endcase
	endfunction

	// Build a packet with a chain of headers; mode picks broken forms.
	task automatic build_packet(int nhdr, int mode);
		logic [7:0] nh;
		int plen;
		int hl;
		int n;
		pkt.delete();
		nh = pick_nh();
		for (int i = 0; i < 40; i++) pkt.push_back(8'($urandom));
		pkt[0] = {4'd6, pkt[0][3:0]};
		if (mode == 1) pkt[0][7:4] = 4'($urandom_range(0, 15));
		pkt[6] = nh;
		for (int h = 0; h < nhdr; h++) begin
			if (!(nh == NH_HOP || nh == NH_ROUTE || nh == NH_DEST || nh == NH_FRAG ||
				nh == NH_AUTH)) break;
			hl = $urandom_range(0, 3);
			if (nh == NH_FRAG) n = 8;
			else if (nh == NH_AUTH) n = (hl + 2) * 4;
			else n = (hl + 1) * 8;
			pkt.push_back(pick_nh());
			pkt.push_back(8'(hl));
			for (int k = 2; k < n; k++) pkt.push_back(8'($urandom));
			nh = pkt[pkt.size() - n];
		end
		n = $urandom_range(0, 12);
		for (int k = 0; k < n; k++) pkt.push_back(8'($urandom));
		if (mode == 2) begin
			n = $urandom_range(1, pkt.size() - 1);
			repeat (n) void'(pkt.pop_back());
		end
		plen = pkt.size() - 40 - ((mode == 3) ? -$urandom_range(1, 3) : $urandom_range(0, 4));
		if (plen < 0) plen = 0;
		if (pkt.size() > 5) begin
			pkt[4] = plen[15:8];
			pkt[5] = plen[7:0];
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	initial begin
		sb = new();
		sb.clear();
		sb.errors = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: single short byte, all-ones, exact 40, destination and fragment headers
		pkt = '{8'hFF}; send_packet();
		pkt.delete(); for (int i = 0; i < 40; i++) pkt.push_back(8'h00);
		pkt[0] = 8'h60; pkt[6] = NH_DEST; send_packet();
		pkt.delete(); for (int i = 0; i < 40; i++) pkt.push_back(8'hFF); send_packet();
		pkt[0] = 8'h6F; pkt[4] = 0; pkt[5] = 0; send_packet();
		pkt.delete(); for (int i = 0; i < 48; i++) pkt.push_back(8'h00);
		pkt[0] = 8'h60; pkt[5] = 8; pkt[6] = NH_FRAG; pkt[40] = 8'd6;
		pkt[42] = 8'hFF; pkt[43] = 8'hF9; send_packet();
		build_packet(4, 0); send_packet();
		build_packet(4, 2); send_packet();
		wait_drain();
		while (byte_total < 1150) begin
			build_packet($urandom_range(0, 4), ($urandom_range(0, 9) < 7) ? 0 :
				$urandom_range(1, 3));
			send_packet();
			if ($urandom_range(0, 4) == 0) wait_drain();
		end
		wait_drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_ipv6_header_chain_parser OK");
		else
			$display("tb_ipv6_header_chain_parser NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
